// File: hdl/lpht_pkg.sv
`timescale 1ns / 1ps
// lpht_pkg: shared constants and controller/datapath interface types
package lpht_pkg;

  localparam int TABLE_SIZE = 13;

  localparam int KEY_W    = 16;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 2;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input word
    logic clr_step;  // clear one slot of the sweep
    logic h1;        // reciprocal multiply
    logic h2;        // quotient times table size
    logic h3;        // remainder correction, start probe
    logic probe;     // one probe step
    logic res_load;  // move result into output register
  } lpht_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic probe_done;
    logic out_busy;
  } lpht_sts_t;

endpackage

// File: hdl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// linear_probe_hash_table: open-addressing hash table with linear probing
//
//   channel | handshake          | payload        | direction
//   --------+--------------------+----------------+----------
//   in      | in_valid, in_stall | mode, key      | into block
//   out     | out_valid, out_stall | slot, status | out of block
//
// insert/search: each word probes 1..TABLE_SIZE slots through the single read port
//   of the slot memory, one slot checked per cycle
// clear: one slot cleared per cycle through the write port of the slot memory
// after reset a clearing pass runs before the first word
// a result waiting in the output register does not block the next input word;
//   only a second finished result waits for out_stall to drop
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lpht_pkg::MODE_W-1:0]   mode,
  input  logic [lpht_pkg::KEY_W-1:0]    key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lpht_pkg::SLOT_W-1:0]   slot,
  output logic [lpht_pkg::STATUS_W-1:0] status
);

  // controller/datapath handoff
  lpht_pkg::lpht_cmd_t cmd;
  lpht_pkg::lpht_sts_t sts;

  // state machine: clear sweep, hash steps, probe loop, result handoff
  lpht_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .mode    (mode),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // hashing by reciprocal multiply, slot memory, probe pointers, output register
  lpht_datapath #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .mode     (mode),
    .key      (key),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .slot     (slot),
    .status   (status)
  );

endmodule

// File: hdl/lpht_ram.sv
`timescale 1ns / 1ps
// lpht_ram: generic simple dual-port ram with registered read
module lpht_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/lpht_ctrl.sv
`timescale 1ns / 1ps
// lpht_ctrl: sequencing state machine for clear sweep, hashing and probing
module lpht_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [lpht_pkg::MODE_W-1:0] mode,
  output logic                       in_stall,
  input  lpht_pkg::lpht_sts_t        sts,
  output lpht_pkg::lpht_cmd_t        cmd
);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_H1    = 3'd2;
  localparam logic [2:0] S_H2    = 3'd3;
  localparam logic [2:0] S_H3    = 3'd4;
  localparam logic [2:0] S_PROBE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state, state_next;
  logic       clr_res, clr_res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_res <= 1'b0;
    end else begin
      state   <= state_next;
      clr_res <= clr_res_next;
    end
  end

  always_comb begin
    state_next   = state;
    clr_res_next = clr_res;
    cmd          = '0;
    in_stall     = 1'b1;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next   = clr_res ? S_DONE : S_IDLE;
          clr_res_next = 1'b0;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (mode)
            lpht_pkg::MODE_CLEAR: begin
              state_next   = S_CLR;
              clr_res_next = 1'b1;
            end
            lpht_pkg::MODE_INSERT: state_next = S_H1;
            lpht_pkg::MODE_SEARCH: state_next = S_H1;
            default:               state_next = S_DONE;
          endcase
        end
      end
      S_H1: begin
        cmd.h1     = 1'b1;
        state_next = S_H2;
      end
      S_H2: begin
        cmd.h2     = 1'b1;
        state_next = S_H3;
      end
      S_H3: begin
        cmd.h3     = 1'b1;
        state_next = S_PROBE;
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.probe_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hdl/lpht_datapath.sv
`timescale 1ns / 1ps
// lpht_datapath: key hashing, slot memory, probe pointers and result registers
module lpht_datapath #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lpht_pkg::lpht_cmd_t           cmd,
  output lpht_pkg::lpht_sts_t           sts,
  input  logic [lpht_pkg::MODE_W-1:0]   mode,
  input  logic [lpht_pkg::KEY_W-1:0]    key,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [lpht_pkg::SLOT_W-1:0]   slot,
  output logic [lpht_pkg::STATUS_W-1:0] status
);

  localparam int SW   = $clog2(TABLE_SIZE);
  localparam int CW   = $clog2(TABLE_SIZE + 1);
  localparam int XW   = (SW > lpht_pkg::SLOT_W) ? SW : lpht_pkg::SLOT_W;
  localparam int KW   = lpht_pkg::KEY_W;
  localparam int PW   = KW + 32;
  localparam int QW   = KW + 11;
  localparam int MW   = KW + 1;
  localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / TABLE_SIZE);
  localparam logic [10:0]   NV    = 11'(TABLE_SIZE);
  localparam logic [SW:0]   NFULL = (SW + 1)'(TABLE_SIZE);
  localparam logic [SW-1:0] LAST  = SW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] CLAST = CW'(TABLE_SIZE - 1);

  logic [KW-1:0]               key_r;
  logic [lpht_pkg::MODE_W-1:0] mode_r;
  logic [PW-1:0]               prod;
  logic [QW-1:0]               qn;
  logic [QW-1:0]               diff;
  logic [SW:0]                 dlo, dsub;
  logic [SW-1:0]               home;

  logic [SW-1:0] rd_ptr, chk_ptr, clr_ptr;
  logic          pend;
  logic [CW-1:0] cnt;

  logic                we;
  logic [SW-1:0]       waddr;
  logic [MW-1:0]       wdata, rdata;
  logic                r_used, r_match, hit, is_ins;
  logic [XW-1:0]       slot_ext;

  logic [lpht_pkg::SLOT_W-1:0]   res_slot;
  logic [lpht_pkg::STATUS_W-1:0] res_status;

  // remainder estimate is below twice the table size; one subtract fixes it
  assign diff = {11'd0, key_r} - qn;
  assign dlo  = diff[SW:0];
  assign dsub = dlo - NFULL;
  assign home = (dlo >= NFULL) ? dsub[SW-1:0] : dlo[SW-1:0];

  assign r_used  = rdata[KW];
  assign r_match = rdata[KW-1:0] == key_r;
  assign is_ins  = mode_r == lpht_pkg::MODE_INSERT;
  assign hit     = pend && (!r_used || (!is_ins && r_match));

  assign slot_ext = XW'(chk_ptr);

  assign we    = cmd.clr_step || (cmd.probe && pend && is_ins && !r_used);
  assign waddr = cmd.clr_step ? clr_ptr : chk_ptr;
  assign wdata = cmd.clr_step ? '0 : {1'b1, key_r};

  assign sts.clr_last   = clr_ptr == LAST;
  assign sts.probe_done = hit || (pend && cnt == CLAST);
  assign sts.out_busy   = out_valid && out_stall;

  lpht_ram #(
    .WIDTH(MW),
    .DEPTH(TABLE_SIZE)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_ptr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr   <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_ptr <= (clr_ptr == LAST) ? '0 : clr_ptr + SW'(1);
      end
      if (cmd.h3) begin
        pend <= 1'b0;
      end else if (cmd.probe) begin
        pend <= 1'b1;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= key;
      mode_r   <= mode;
      res_slot <= '0;
      case (mode)
        lpht_pkg::MODE_INSERT: res_status <= lpht_pkg::ST_FULL;
        lpht_pkg::MODE_SEARCH: res_status <= lpht_pkg::ST_NOTFOUND;
        default:               res_status <= lpht_pkg::ST_OK;
      endcase
    end
    if (cmd.h1) begin
      prod <= PW'(key_r) * PW'(RECIP);
    end
    if (cmd.h2) begin
      qn <= prod[PW-1:32] * NV;
    end
    if (cmd.h3) begin
      rd_ptr <= home;
      cnt    <= '0;
    end
    if (cmd.probe) begin
      rd_ptr  <= (rd_ptr == LAST) ? '0 : rd_ptr + SW'(1);
      chk_ptr <= rd_ptr;
      if (pend) begin
        cnt <= cnt + CW'(1);
      end
      if (pend && (!r_used ? is_ins : (!is_ins && r_match))) begin
        res_slot   <= slot_ext[lpht_pkg::SLOT_W-1:0];
        res_status <= lpht_pkg::ST_OK;
      end
    end
    if (cmd.res_load) begin
      slot   <= res_slot;
      status <= res_status;
    end
  end

endmodule

// File: hdl/lpht_checker.sv
`timescale 1ns / 1ps
// lpht_checker: port-level assertions for the hash table, bound to the top level
module lpht_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [lpht_pkg::SLOT_W-1:0]   slot,
  input logic [lpht_pkg::STATUS_W-1:0] status
);

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(slot) && $stable(status))
    else $error("output word changed while stalled");

  // only three status codes exist
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == lpht_pkg::ST_OK || status == lpht_pkg::ST_NOTFOUND ||
      status == lpht_pkg::ST_FULL)
    else $error("bad status code");

  // misses and full table report slot zero
  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != lpht_pkg::ST_OK |-> slot == '0)
    else $error("nonzero slot on failure");

  // an accepted word occupies the block for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .slot     (slot),
  .status   (status)
);

// File: test/linear_probe_hash_table_tb.sv
`timescale 1ns / 1ps
// linear_probe_hash_table_tb: self-checking testbench, table predictor and random handshakes
module linear_probe_hash_table_tb;

  // mode 3 has no operation; the block answers ok and leaves the table alone
  localparam logic [lpht_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1100;
  localparam int QUIET_WORDS  = 150;   // tail of the run with no idling at all
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to back the block up

  typedef struct {
    logic [lpht_pkg::SLOT_W-1:0]   slot;
    logic [lpht_pkg::STATUS_W-1:0] status;
  } result_t;

  // table predictor and the queue of results still owed by the block
  class table_scoreboard;
    logic [lpht_pkg::KEY_W-1:0] stored_key [lpht_pkg::TABLE_SIZE];
    bit                         slot_taken [lpht_pkg::TABLE_SIZE];
    result_t                    owed_results[$];
    int errors;
    int n_clear, n_insert, n_full, n_search, n_miss, n_unused;

    // apply one word to the predicted table and return the answer it gives
    function result_t probe_table(logic [lpht_pkg::MODE_W-1:0] m,
                                  logic [lpht_pkg::KEY_W-1:0] k);
      result_t r;
      int      s;
      bit      done;
      r.slot   = '0;
      r.status = lpht_pkg::ST_OK;
      s        = int'(k) % lpht_pkg::TABLE_SIZE;
      done     = 1'b0;
      case (m)
        lpht_pkg::MODE_CLEAR: begin
          foreach (slot_taken[i]) slot_taken[i] = 1'b0;
          n_clear++;
        end
        lpht_pkg::MODE_INSERT: begin
          n_insert++;
          r.status = lpht_pkg::ST_FULL;
          for (int n = 0; n < lpht_pkg::TABLE_SIZE && !done; n++) begin
            if (!slot_taken[s]) begin
              stored_key[s] = k;
              slot_taken[s] = 1'b1;
              r.slot        = lpht_pkg::SLOT_W'(s);
              r.status      = lpht_pkg::ST_OK;
              done          = 1'b1;
            end else begin
              s = (s + 1 == lpht_pkg::TABLE_SIZE) ? 0 : s + 1;
            end
          end
          if (!done) n_full++;
        end
        lpht_pkg::MODE_SEARCH: begin
          n_search++;
          r.status = lpht_pkg::ST_NOTFOUND;
          for (int n = 0; n < lpht_pkg::TABLE_SIZE && !done; n++) begin
            if (!slot_taken[s]) begin
              done = 1'b1;
            end else if (stored_key[s] == k) begin
              r.slot   = lpht_pkg::SLOT_W'(s);
              r.status = lpht_pkg::ST_OK;
              done     = 1'b1;
            end else begin
              s = (s + 1 == lpht_pkg::TABLE_SIZE) ? 0 : s + 1;
            end
          end
          if (r.status == lpht_pkg::ST_NOTFOUND) n_miss++;
        end
        default: n_unused++;
      endcase
      return r;
    endfunction

    function void note_word(logic [lpht_pkg::MODE_W-1:0] m, logic [lpht_pkg::KEY_W-1:0] k);
      owed_results.push_back(probe_table(m, k));
    endfunction

    function void check_result(logic [lpht_pkg::SLOT_W-1:0] s,
                               logic [lpht_pkg::STATUS_W-1:0] st);
      result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got slot %0d status %0d",
                 $time, s, st);
        errors++;
      end else begin
        want = owed_results.pop_front();
        if (s !== want.slot) begin
          $display("%0t: slot mismatch, expected %0d, got %0d", $time, want.slot, s);
          errors++;
        end
        if (st !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, st);
          errors++;
        end
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [lpht_pkg::MODE_W-1:0]   mode;
  logic [lpht_pkg::KEY_W-1:0]    key;
  logic                          out_valid;
  logic                          out_stall;
  logic [lpht_pkg::SLOT_W-1:0]   slot;
  logic [lpht_pkg::STATUS_W-1:0] status;

  table_scoreboard sb = new();

  // idling control shared by the sender, the receiver and the main sequence
  bit quiet;      // no idling on either side
  bit hold_req;   // main sequence asks the receiver for one long hold-off
  bit holding;    // receiver is in that hold-off; sender keeps words coming

  logic [lpht_pkg::KEY_W-1:0] inserted_keys[$];   // keys inserted since the last clear

  linear_probe_hash_table uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .slot      (slot),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard limit, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // offer one word and hold it until accepted, then maybe idle for a burst
  task automatic send_word(input logic [lpht_pkg::MODE_W-1:0] m,
                           input logic [lpht_pkg::KEY_W-1:0] k);
    mode     <= m;
    key      <= k;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(m, k);
    if (!quiet && !holding && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // a key whose home slot is the given one, with random upper bits
  function automatic logic [lpht_pkg::KEY_W-1:0] key_at_home(int home);
    int k;
    k = ($urandom_range(0, 65535) / lpht_pkg::TABLE_SIZE) * lpht_pkg::TABLE_SIZE + home;
    if (k > 65535) k -= lpht_pkg::TABLE_SIZE;
    return lpht_pkg::KEY_W'(k);
  endfunction

  // result monitor: values sampled here are the ones that held before the edge
  always @(posedge clk) begin
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(slot, status);
  end

  // receiver: random stall bursts, one long hold-off on request, none when quiet
  initial begin
    out_stall <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        holding  = 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int sent;
    int nops;
    int base;
    int pick;
    bit hold_done;
    logic [lpht_pkg::KEY_W-1:0] k;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    mode      <= lpht_pkg::MODE_CLEAR;
    key       <= '0;
    sent      = 0;
    hold_done = 1'b0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    holding   = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part: empty-table miss, collisions, wrap-around, full table
    send_word(lpht_pkg::MODE_SEARCH, 16'd0);      // empty table, stops at first slot
    send_word(lpht_pkg::MODE_INSERT, 16'd0);      // home 0
    send_word(lpht_pkg::MODE_INSERT, 16'hFFFF);   // home 2, all key bits set
    send_word(lpht_pkg::MODE_INSERT, 16'd13);     // home 0 taken, lands in 1
    send_word(lpht_pkg::MODE_INSERT, 16'd26);     // home 0, probes past 1 and 2
    send_word(lpht_pkg::MODE_SEARCH, 16'd26);
    send_word(lpht_pkg::MODE_SEARCH, 16'hFFFF);
    send_word(lpht_pkg::MODE_SEARCH, 16'd39);     // miss at the first empty slot
    send_word(MODE_UNUSED, 16'hFFFF);             // no-op mode
    send_word(lpht_pkg::MODE_INSERT, 16'd12);     // last slot
    send_word(lpht_pkg::MODE_INSERT, 16'd25);     // wraps from the last slot to 0 and on
    for (int h = 5; h <= 11; h++)
      send_word(lpht_pkg::MODE_INSERT, lpht_pkg::KEY_W'(h));   // fills the table
    send_word(lpht_pkg::MODE_INSERT, 16'd100);    // rejected, table full
    send_word(lpht_pkg::MODE_SEARCH, 16'd1000);   // full table, probes every slot, miss
    send_word(lpht_pkg::MODE_SEARCH, 16'd25);     // found after wrap
    send_word(lpht_pkg::MODE_CLEAR, 16'h5A5A);
    send_word(lpht_pkg::MODE_SEARCH, 16'd25);     // cleared, so a miss
    send_word(lpht_pkg::MODE_INSERT, 16'd25);
    send_word(lpht_pkg::MODE_CLEAR, 16'd0);

    // random part: mostly clear then a run of clustered inserts and searches,
    // so probe chains grow long, wrap and often fill the table
    while (sent < RANDOM_WORDS) begin
      quiet = (sent >= RANDOM_WORDS - QUIET_WORDS);
      if (sent >= 300 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 7) != 0) begin
        send_word(lpht_pkg::MODE_CLEAR, lpht_pkg::KEY_W'($urandom_range(0, 65535)));
        inserted_keys.delete();
        sent++;
      end
      nops = $urandom_range(4, 36);
      base = $urandom_range(0, lpht_pkg::TABLE_SIZE - 1);
      for (int i = 0; i < nops; i++) begin
        // three quarters of keys land near one home slot to force collisions
        if ($urandom_range(0, 3) != 0)
          k = key_at_home((base + $urandom_range(0, 2)) % lpht_pkg::TABLE_SIZE);
        else
          k = lpht_pkg::KEY_W'($urandom_range(0, 65535));
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
          send_word(lpht_pkg::MODE_INSERT, k);
          inserted_keys.push_back(k);
        end else if (pick < 15 && inserted_keys.size() != 0) begin
          send_word(lpht_pkg::MODE_SEARCH,
                    inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
        end else if (pick < 19) begin
          send_word(lpht_pkg::MODE_SEARCH, k);
        end else begin
          send_word(MODE_UNUSED, k);
        end
        sent++;
      end
    end
    in_valid <= 1'b0;

    // drain, then wait for any stray output
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d clears, %0d inserts (%0d into a full table), %0d no-op words",
             sb.n_clear, sb.n_insert, sb.n_full, sb.n_unused);
    $display("covered %0d searches (%0d misses), one long output hold-off",
             sb.n_search, sb.n_miss);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lpht_pkg.sv
hdl/lpht_ram.sv
hdl/lpht_ctrl.sv
hdl/lpht_datapath.sv
hdl/linear_probe_hash_table.sv
hdl/lpht_checker.sv
test/linear_probe_hash_table_tb.sv
